@@ src/tvne_pkg.sv @@
// Package for the tiled variance noise estimator.
// Shared constants, default sizes, port widths, register indexes and status codes.
// No dependencies.
`timescale 1ns / 1ps

package tvne_pkg;

  localparam int DefMaxDim     = 1024;
  localparam int DefTileSize   = 32;
  localparam int DefSampleBits = 20;

  localparam int CfgWidth      = 11;
  localparam int CfgIdxWidth   = 1;
  localparam int SampleWidth   = 20;
  localparam int InDataWidth   = 24;
  localparam int NoiseWidth    = 30;
  localparam int StatusWidth   = 2;
  localparam int OutDataWidth  = 64;

  localparam logic [CfgIdxWidth-1:0] CfgXSize = 1'b0;
  localparam logic [CfgIdxWidth-1:0] CfgYSize = 1'b1;

  localparam logic [StatusWidth-1:0] StatusOk       = 2'd0;
  localparam logic [StatusWidth-1:0] StatusNoTile   = 2'd1;
  localparam logic [StatusWidth-1:0] StatusRejected = 2'd2;

endpackage

@@ src/tiled_variance_noise_estimator_core.sv @@
// Tiled variance noise estimator, top level.
// Depends on tvne_pkg. Holds strip accumulators, the tile store and the frame-end selection.
`timescale 1ns / 1ps

// Samples arrive row-major on s_*, one frame of y_size rows by x_size samples. Each sample
// passes the read, square and write back through the strip memory before the next one is
// taken; one that closes a tile also computes and stores its tile variance. After the last
// sample of a frame the block stops taking samples and computes the noise level: each
// median is found one value bit per scan over the tile memory, so a median takes VW scans
// (VW = 60 by default), a keep/reject scan follows, and each square root yields VW/2 bits.
// One result transaction per frame is sent on m_*; a configuration write restarts the frame.
module tiled_variance_noise_estimator_core #(
  parameter int MAX_DIM     = tvne_pkg::DefMaxDim,
  parameter int TILE_SIZE   = tvne_pkg::DefTileSize,
  parameter int SAMPLE_BITS = tvne_pkg::DefSampleBits
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wen,
  input  logic [tvne_pkg::CfgIdxWidth-1:0]     cfg_index,
  input  logic [tvne_pkg::CfgWidth-1:0]        cfg_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [tvne_pkg::InDataWidth-1:0]     s_tdata,   // [19:0] sample
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [29:0] noise_est, [59:30] first_est, [61:60] status
  output logic [tvne_pkg::OutDataWidth-1:0]    m_tdata
);

  localparam int TileArea  = TILE_SIZE * TILE_SIZE;
  localparam int AW        = $clog2(TileArea);
  localparam int Strips    = (MAX_DIM / TILE_SIZE > 0) ? MAX_DIM / TILE_SIZE : 1;
  localparam int MaxTiles  = Strips * Strips;
  localparam int KW        = (Strips > 1) ? $clog2(Strips) : 1;
  localparam int TIW       = (MaxTiles > 1) ? $clog2(MaxTiles) : 1;
  localparam int TCW       = $clog2(MaxTiles + 1);
  localparam int DWRaw     = $clog2(MAX_DIM + TILE_SIZE + 1);
  localparam int DW        = (DWRaw > 12) ? DWRaw : 12;
  localparam int TPW       = $clog2(TILE_SIZE);
  localparam int SW        = SAMPLE_BITS + AW;          // signed tile sum
  localparam int QW        = 2 * SAMPLE_BITS + AW;      // tile sum of squares
  localparam int VW        = QW + AW;                   // scaled variance
  localparam int PW        = SAMPLE_BITS + AW;          // area * peak
  localparam int NI        = VW / 2;
  localparam int RW        = NI + 2;
  localparam int LW        = VW + 7;
  localparam int NIW       = $clog2(NI + 1);

  localparam logic [DW-1:0]  MaxDimD  = DW'(MAX_DIM);
  localparam logic [DW-1:0]  TileD    = DW'(TILE_SIZE);
  localparam logic [TPW-1:0] TileLast = TPW'(TILE_SIZE - 1);
  localparam logic [QW-1:0]  AreaQ    = QW'(TileArea);
  localparam logic [PW-1:0]  AreaP    = PW'(TileArea);

  typedef struct packed {
    logic signed [SW-1:0] sum;
    logic [QW-1:0]        sq;
    logic [SAMPLE_BITS-1:0] peak;
  } strip_t;

  typedef struct packed {
    logic [VW-1:0]          var_v;
    logic [SAMPLE_BITS-1:0] peak;
  } tile_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_UPD, ST_VAR1, ST_VAR2, ST_FIN, ST_SCAN, ST_SEL, ST_ROOT, ST_OUT
  } state_t;

  typedef enum logic [1:0] {PH_MED1, PH_KEEP, PH_MED2} phase_t;

  state_t state;
  phase_t phase;

  // configuration
  logic [tvne_pkg::CfgWidth-1:0] x_size, y_size;
  logic [DW-1:0] xs_c, ys_c;

  // frame position
  logic [DW-1:0]  col, row, cbase, rbase;
  logic [TPW-1:0] cin, rin;
  logic [KW-1:0]  kidx;
  logic [TCW-1:0] tile_count;

  // per-sample work registers
  logic signed [SAMPLE_BITS-1:0] smp;
  logic [SAMPLE_BITS-1:0]        mag;
  logic [2*SAMPLE_BITS-1:0]      msq;
  logic                          in_tile, first_s, last_s, frame_end;
  logic [KW-1:0]                 k_r;

  strip_t strip_mem [Strips];
  strip_t strip_rd, strip_new, strip_base;
  logic   strip_we;

  logic signed [SW-1:0]   tsum;
  logic [QW-1:0]          tsq;
  logic [SAMPLE_BITS-1:0] tpeak;
  logic [SW-1:0]          tabs;
  logic [2*SW-1:0]        ssq;

  tile_t tile_mem [MaxTiles];
  tile_t tile_rd;
  logic  tile_we;

  // selection scan
  logic [TCW-1:0] scan_i, cnt, ksel;
  logic           v1, v2;
  logic [VW-1:0]  var_d, pref, hmask, cur;
  logic [VW-1:0]  pp;
  logic [LW-1:0]  lim;
  logic [VW-1:0]  sel_val;
  logic           match, drop, cnt_en, take1;
  logic [VW-1:0]  pref_fin;

  // square root
  logic [VW-1:0]  rt_v;
  logic [RW-1:0]  rt_rem;
  logic [NI-1:0]  rt_root;
  logic [NIW-1:0] rt_cnt;
  logic [RW+1:0]  rt_rem2, rt_trial;

  logic [tvne_pkg::NoiseWidth-1:0]  res_noise, res_first;
  logic [tvne_pkg::StatusWidth-1:0] res_status;

  logic s_acc;
  logic signed [SAMPLE_BITS-1:0] s_in;

  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign s_in     = s_tdata[SAMPLE_BITS-1:0];

  always_comb begin
    if (x_size == '0) xs_c = DW'(1);
    else if (DW'(x_size) > MaxDimD) xs_c = MaxDimD;
    else xs_c = DW'(x_size);
    if (y_size == '0) ys_c = DW'(1);
    else if (DW'(y_size) > MaxDimD) ys_c = MaxDimD;
    else ys_c = DW'(y_size);
  end

  always_comb begin
    strip_base = first_s ? '0 : strip_rd;
    strip_new.sum  = strip_base.sum + SW'(smp);
    strip_new.sq   = strip_base.sq + QW'(msq);
    strip_new.peak = (mag > strip_base.peak) ? mag : strip_base.peak;
    strip_we = (state == ST_UPD) && in_tile;
    tile_we  = (state == ST_VAR2);
    tabs     = tsum[SW-1] ? SW'(-tsum) : SW'(tsum);
  end

  // memories; the strip entry of the sample in flight is read in ST_SQ
  always_ff @(posedge clk) begin
    if (strip_we) strip_mem[k_r] <= strip_new;
    strip_rd <= strip_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (tile_we) begin
      tile_mem[tile_count[TIW-1:0]] <= '{var_v: VW'(tsq * AreaQ) - VW'(ssq), peak: tpeak};
    end
    tile_rd <= tile_mem[scan_i[TIW-1:0]];
  end

  // selection pipeline datapath
  always_comb begin
    match   = ((var_d ^ pref) & hmask) == '0;
    drop    = LW'(pp) > lim;
    unique case (phase)
      PH_MED1: cnt_en = match;
      PH_KEEP: cnt_en = !drop;
      PH_MED2: cnt_en = match && !drop;
      default: cnt_en = 1'b0;
    endcase
    take1    = !(ksel < cnt);
    pref_fin = take1 ? (pref | cur) : pref;
    rt_rem2  = {rt_rem, rt_v[VW-1:VW-2]};
    rt_trial = (RW+2)'({rt_root, 2'b01});
  end

  always_ff @(posedge clk) begin
    var_d <= tile_rd.var_v;
    pp    <= VW'((tile_rd.peak * AreaP) * (tile_rd.peak * AreaP));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= PH_MED1;
      x_size     <= tvne_pkg::CfgWidth'(tvne_pkg::DefMaxDim);
      y_size     <= tvne_pkg::CfgWidth'(tvne_pkg::DefMaxDim);
      col        <= '0;
      row        <= '0;
      cbase      <= '0;
      rbase      <= '0;
      cin        <= '0;
      rin        <= '0;
      kidx       <= '0;
      tile_count <= '0;
      frame_end  <= 1'b0;
      m_tvalid   <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      v1 <= (state == ST_SCAN) && (scan_i < tile_count);
      v2 <= v1;

      if (cfg_wen) begin
        if (cfg_index == tvne_pkg::CfgXSize) x_size <= cfg_data;
        else y_size <= cfg_data;
        col <= '0; row <= '0; cbase <= '0; rbase <= '0;
        cin <= '0; rin <= '0; kidx <= '0; tile_count <= '0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_acc) begin
            smp       <= s_in;
            mag       <= s_in[SAMPLE_BITS-1] ? SAMPLE_BITS'(-s_in) : SAMPLE_BITS'(s_in);
            in_tile   <= (cbase + TileD <= xs_c) && (rbase + TileD <= ys_c);
            first_s   <= (cin == '0) && (rin == '0);
            last_s    <= (cin == TileLast) && (rin == TileLast);
            k_r       <= kidx;
            frame_end <= 1'b0;
            if (col + DW'(1) >= xs_c) begin
              col <= '0; cin <= '0; cbase <= '0; kidx <= '0;
              if (row + DW'(1) >= ys_c) begin
                frame_end <= 1'b1;
                row <= '0; rin <= '0; rbase <= '0;
              end else begin
                row <= row + DW'(1);
                if (rin == TileLast) begin
                  rin   <= '0;
                  rbase <= rbase + TileD;
                end else begin
                  rin <= rin + TPW'(1);
                end
              end
            end else begin
              col <= col + DW'(1);
              if (cin == TileLast) begin
                cin   <= '0;
                cbase <= cbase + TileD;
                kidx  <= kidx + KW'(1);
              end else begin
                cin <= cin + TPW'(1);
              end
            end
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          msq   <= mag * mag;
          state <= ST_UPD;
        end
        ST_UPD: begin
          tsum  <= strip_new.sum;
          tsq   <= strip_new.sq;
          tpeak <= strip_new.peak;
          if (in_tile && last_s) state <= ST_VAR1;
          else state <= frame_end ? ST_FIN : ST_IDLE;
        end
        ST_VAR1: begin
          ssq   <= tabs * tabs;
          state <= ST_VAR2;
        end
        ST_VAR2: begin
          tile_count <= tile_count + TCW'(1);
          state      <= frame_end ? ST_FIN : ST_IDLE;
        end
        ST_FIN: begin
          if (tile_count == '0) begin
            res_status <= tvne_pkg::StatusNoTile;
            res_first  <= '0;
            res_noise  <= '0;
            state      <= ST_OUT;
          end else begin
            phase  <= PH_MED1;
            ksel   <= tile_count >> 1;
            pref   <= '0;
            cur    <= {1'b1, {(VW-1){1'b0}}};
            hmask  <= {1'b1, {(VW-1){1'b0}}};
            scan_i <= '0;
            cnt    <= '0;
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_i < tile_count) scan_i <= scan_i + TCW'(1);
          if (v2 && cnt_en) cnt <= cnt + TCW'(1);
          if (!(scan_i < tile_count) && !v1 && !v2) state <= ST_SEL;
        end
        ST_SEL: begin
          scan_i <= '0;
          cnt    <= '0;
          if (phase == PH_KEEP) begin
            if (cnt == '0) begin
              res_status <= tvne_pkg::StatusRejected;
              res_noise  <= '0;
              state      <= ST_OUT;
            end else begin
              phase <= PH_MED2;
              ksel  <= cnt >> 1;
              pref  <= '0;
              cur   <= {1'b1, {(VW-1){1'b0}}};
              hmask <= {1'b1, {(VW-1){1'b0}}};
              state <= ST_SCAN;
            end
          end else begin
            pref <= pref_fin;
            if (take1) ksel <= ksel - cnt;
            if (cur[0]) begin
              sel_val <= pref_fin;
              rt_v    <= pref_fin;
              rt_rem  <= '0;
              rt_root <= '0;
              rt_cnt  <= NIW'(NI);
              state   <= ST_ROOT;
            end else begin
              cur   <= cur >> 1;
              hmask <= hmask | (cur >> 1);
              state <= ST_SCAN;
            end
          end
        end
        ST_ROOT: begin
          if (rt_cnt == '0) begin
            if (phase == PH_MED1) begin
              res_first <= tvne_pkg::NoiseWidth'(rt_root);
              lim       <= (LW'(sel_val) << 6) + (LW'(sel_val) << 5) + (LW'(sel_val) << 2);
              phase     <= PH_KEEP;
              scan_i    <= '0;
              cnt       <= '0;
              state     <= ST_SCAN;
            end else begin
              res_noise  <= tvne_pkg::NoiseWidth'(rt_root);
              res_status <= tvne_pkg::StatusOk;
              state      <= ST_OUT;
            end
          end else begin
            rt_v   <= rt_v << 2;
            rt_cnt <= rt_cnt - NIW'(1);
            if (rt_rem2 >= rt_trial) begin
              rt_rem  <= RW'(rt_rem2 - rt_trial);
              rt_root <= {rt_root[NI-2:0], 1'b1};
            end else begin
              rt_rem  <= RW'(rt_rem2);
              rt_root <= {rt_root[NI-2:0], 1'b0};
            end
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= {2'b00, res_status, res_first, res_noise};
            tile_count <= '0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_tile_count_bound: assert property (@(posedge clk) disable iff (rst)
    tile_count <= TCW'(MaxTiles))
    else $error("tile count above tile store depth");

  a_one_sample_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("sample taken while previous one in flight");

  a_no_tile_zero_levels: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[61:60] == tvne_pkg::StatusNoTile |-> m_tdata[59:0] == '0)
    else $error("noise levels nonzero without any tile");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[61:60] != 2'd3 && m_tdata[63:62] == 2'b00)
    else $error("bad result status or padding");
`endif

endmodule
